/* rtl/ted_pkg.sv */
// package for the toric edge distance block: widths, register codes, helpers
`timescale 1ns / 1ps
package ted_pkg;
   localparam int MaxSideDefault = 256;
   localparam int RegWidth       = 9;
   localparam int EdgeWidth      = 17;
   localparam int DistWidth      = 9;
   localparam int CsrIdxWidth    = 1;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] RegRows = 1'd0;
   localparam logic [CsrIdxWidth-1:0] RegCols = 1'd1;

   // clamp a side register to the legal range
   function automatic logic [RegWidth-1:0] eff_side(input logic [RegWidth-1:0] r,
                                                    input int max_side);
      logic [RegWidth-1:0] v;
      v = r;
      if (r < RegWidth'(2)) v = RegWidth'(2);
      else if (int'(r) > max_side) v = RegWidth'(max_side);
      return v;
   endfunction
endpackage

/* rtl/toric_edge_distance.sv */
// top level: toric lattice edge distance pipeline
`timescale 1ns / 1ps
// Usage
//   csr_*: write rows (index 0) or cols (index 1) while the block is idle;
//     values below 2 act as 2, above MAX_SIDE as MAX_SIDE.
//   req_*: one item carries edge_a and edge_b; rsp_* returns distance and
//     out_of_range for each item, in order.
// Timing
//   a chain of division cells splits each vertex into column and row, one
//   quotient bit per cell (16 cells), followed by 3 cells for end vertices,
//   pair distances and the minimum, plus one input cell.
//   one item per cycle is accepted when the receiver keeps up.
// Stalls
//   the whole chain advances only when the output cell is empty or taken;
//   a stalled receiver holds every cell, and req_tready follows.
// Reset
//   rows and cols return to 4, all cells empty.
module toric_edge_distance #(
   parameter int MAX_SIDE = ted_pkg::MaxSideDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [ted_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [ted_pkg::RegWidth-1:0]    csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [39:0]                     req_tdata,   // edge_a[16:0], edge_b[33:17], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata    // distance[8:0], out_of_range[9], zero pad
);
   import ted_pkg::*;

   localparam int VW = EdgeWidth - 1;
   localparam int SW = RegWidth;
   localparam int NC = VW;

   logic [RegWidth-1:0] rows_ff, cols_ff;
   logic                en;
   logic [SW-1:0]       nr_q, nc_q;
   logic [EdgeWidth-1:0] ea, eb;
   logic [2*SW:0]       limit;
   logic                s0_v_ff, s0_oor_ff, s0_da_ff, s0_db_ff;
   logic [VW-1:0]       s0_ua_ff, s0_ub_ff;
   logic [SW-1:0]       s0_nc_ff, s0_nr_ff;

   logic          c_v   [NC+1];
   logic [VW-1:0] c_ra  [NC+1], c_qa [NC+1], c_rb [NC+1], c_qb [NC+1];
   logic [SW-1:0] c_nc  [NC+1], c_nr [NC+1];
   logic          c_da  [NC+1], c_db [NC+1], c_oor [NC+1];

   logic                 out_v;
   logic [DistWidth-1:0] out_dist;
   logic                 out_oor;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= RegWidth'(4);
         cols_ff <= RegWidth'(4);
      end else if (csr_we) begin
         case (csr_index)
            RegRows: rows_ff <= csr_wdata;
            RegCols: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign en         = !out_v || rsp_tready;
   assign req_tready = en;
   assign nr_q  = eff_side(rows_ff, MAX_SIDE);
   assign nc_q  = eff_side(cols_ff, MAX_SIDE);
   assign ea    = req_tdata[EdgeWidth-1:0];
   assign eb    = req_tdata[2*EdgeWidth-1:EdgeWidth];
   assign limit = {(2*SW)'(nr_q) * (2*SW)'(nc_q), 1'b0};

   // input cell: range check and vertex index
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_tvalid;
      end
      if (en) begin
         s0_oor_ff <= ((2*SW+1)'(ea) >= limit) || ((2*SW+1)'(eb) >= limit);
         s0_ua_ff  <= ea[EdgeWidth-1:1];
         s0_ub_ff  <= eb[EdgeWidth-1:1];
         s0_da_ff  <= ea[0];
         s0_db_ff  <= eb[0];
         s0_nc_ff  <= nc_q;
         s0_nr_ff  <= nr_q;
      end
   end

   assign c_v[0]   = s0_v_ff;
   assign c_ra[0]  = s0_ua_ff;
   assign c_qa[0]  = '0;
   assign c_rb[0]  = s0_ub_ff;
   assign c_qb[0]  = '0;
   assign c_nc[0]  = s0_nc_ff;
   assign c_nr[0]  = s0_nr_ff;
   assign c_da[0]  = s0_da_ff;
   assign c_db[0]  = s0_db_ff;
   assign c_oor[0] = s0_oor_ff;

   // chain of division cells
   for (genvar k = 0; k < NC; k++) begin : g_div
      ted_div_cell #(.VW(VW), .SW(SW), .STEP(k)) u_cell (
         .clock, .reset, .en,
         .valid_in(c_v[k]), .rem_a_in(c_ra[k]), .quo_a_in(c_qa[k]),
         .rem_b_in(c_rb[k]), .quo_b_in(c_qb[k]), .nc_in(c_nc[k]), .nr_in(c_nr[k]),
         .dir_a_in(c_da[k]), .dir_b_in(c_db[k]), .oor_in(c_oor[k]),
         .valid_out(c_v[k+1]), .rem_a_out(c_ra[k+1]), .quo_a_out(c_qa[k+1]),
         .rem_b_out(c_rb[k+1]), .quo_b_out(c_qb[k+1]), .nc_out(c_nc[k+1]),
         .nr_out(c_nr[k+1]), .dir_a_out(c_da[k+1]), .dir_b_out(c_db[k+1]),
         .oor_out(c_oor[k+1])
      );
   end

   ted_dist_tail #(.VW(VW), .SW(SW)) u_tail (
      .clock, .reset, .en,
      .valid_in(c_v[NC]), .xa(c_ra[NC]), .ya(c_qa[NC]), .xb(c_rb[NC]), .yb(c_qb[NC]),
      .nc(c_nc[NC]), .nr(c_nr[NC]), .dir_a(c_da[NC]), .dir_b(c_db[NC]),
      .oor(c_oor[NC]), .valid_out(out_v), .distance(out_dist), .out_of_range(out_oor)
   );

   assign rsp_tvalid = out_v;
   assign rsp_tdata  = {6'd0, out_oor, out_dist};

`ifndef SYNTHESIS
   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   // flagged items carry zero distance
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DistWidth] |-> rsp_tdata[DistWidth-1:0] == '0)
      else $error("out of range with nonzero distance");
   // ready follows the output cell
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
`endif
endmodule

/* rtl/ted_div_cell.sv */
// one restoring division step of the vertex split, plus payload carried alongside
`timescale 1ns / 1ps
module ted_div_cell #(
   parameter int VW   = 16,
   parameter int SW   = 9,
   parameter int STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  logic [VW-1:0] rem_a_in,
   input  logic [VW-1:0] quo_a_in,
   input  logic [VW-1:0] rem_b_in,
   input  logic [VW-1:0] quo_b_in,
   input  logic [SW-1:0] nc_in,
   input  logic [SW-1:0] nr_in,
   input  logic          dir_a_in,
   input  logic          dir_b_in,
   input  logic          oor_in,
   output logic          valid_out,
   output logic [VW-1:0] rem_a_out,
   output logic [VW-1:0] quo_a_out,
   output logic [VW-1:0] rem_b_out,
   output logic [VW-1:0] quo_b_out,
   output logic [SW-1:0] nc_out,
   output logic [SW-1:0] nr_out,
   output logic          dir_a_out,
   output logic          dir_b_out,
   output logic          oor_out
);
   localparam int SH = VW - 1 - STEP;
   localparam int DW = VW + SW;

   logic          valid_ff;
   logic [VW-1:0] rem_a_ff, quo_a_ff, rem_b_ff, quo_b_ff;
   logic [VW-1:0] rem_a_in2, quo_a_in2, rem_b_in2, quo_b_in2;
   logic [SW-1:0] nc_ff, nr_ff;
   logic          dir_a_ff, dir_b_ff, oor_ff;
   logic [DW-1:0] dsh;

   // try to subtract nc shifted to this bit position
   always_comb begin
      dsh       = DW'(nc_in) << SH;
      rem_a_in2 = rem_a_in;
      quo_a_in2 = quo_a_in;
      rem_b_in2 = rem_b_in;
      quo_b_in2 = quo_b_in;
      if (DW'(rem_a_in) >= dsh) begin
         rem_a_in2     = VW'(DW'(rem_a_in) - dsh);
         quo_a_in2[SH] = 1'b1;
      end
      if (DW'(rem_b_in) >= dsh) begin
         rem_b_in2     = VW'(DW'(rem_b_in) - dsh);
         quo_b_in2[SH] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         rem_a_ff <= rem_a_in2;
         quo_a_ff <= quo_a_in2;
         rem_b_ff <= rem_b_in2;
         quo_b_ff <= quo_b_in2;
         nc_ff    <= nc_in;
         nr_ff    <= nr_in;
         dir_a_ff <= dir_a_in;
         dir_b_ff <= dir_b_in;
         oor_ff   <= oor_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_a_out = rem_a_ff;
   assign quo_a_out = quo_a_ff;
   assign rem_b_out = rem_b_ff;
   assign quo_b_out = quo_b_ff;
   assign nc_out    = nc_ff;
   assign nr_out    = nr_ff;
   assign dir_a_out = dir_a_ff;
   assign dir_b_out = dir_b_ff;
   assign oor_out   = oor_ff;
endmodule

/* rtl/ted_dist_tail.sv */
// end-vertex coordinates, folded distances and the minimum over four pairs
`timescale 1ns / 1ps
module ted_dist_tail #(
   parameter int VW = 16,
   parameter int SW = 9
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              valid_in,
   input  logic [VW-1:0]                     xa,
   input  logic [VW-1:0]                     ya,
   input  logic [VW-1:0]                     xb,
   input  logic [VW-1:0]                     yb,
   input  logic [SW-1:0]                     nc,
   input  logic [SW-1:0]                     nr,
   input  logic                              dir_a,
   input  logic                              dir_b,
   input  logic                              oor,
   output logic                              valid_out,
   output logic [ted_pkg::DistWidth-1:0]     distance,
   output logic                              out_of_range
);
   import ted_pkg::*;

   logic [SW-1:0] ax_ff [2], ay_ff [2], bx_ff [2], by_ff [2];
   logic [SW-1:0] ax_in [2], ay_in [2], bx_in [2], by_in [2];
   logic [SW-1:0] nc_ff, nr_ff;
   logic          v1_ff, v2_ff, oor1_ff, oor2_ff;
   logic [SW:0]   dp_ff [4];
   logic [SW:0]   dp_in [4];
   logic [DistWidth-1:0] dist_ff, dist_in;

   function automatic logic [SW-1:0] fold(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                          input logic [SW-1:0] p);
      logic [SW-1:0] d, r;
      d = (a > b) ? a - b : b - a;
      r = p - d;
      return (d > r) ? r : d;
   endfunction

   // second end: up steps the row, right steps the column, both wrap
   always_comb begin
      ax_in[0] = SW'(xa); ay_in[0] = SW'(ya);
      bx_in[0] = SW'(xb); by_in[0] = SW'(yb);
      ax_in[1] = ax_in[0]; ay_in[1] = ay_in[0];
      bx_in[1] = bx_in[0]; by_in[1] = by_in[0];
      if (dir_a) ax_in[1] = (ax_in[0] == nc - SW'(1)) ? '0 : ax_in[0] + SW'(1);
      else       ay_in[1] = (ay_in[0] == nr - SW'(1)) ? '0 : ay_in[0] + SW'(1);
      if (dir_b) bx_in[1] = (bx_in[0] == nc - SW'(1)) ? '0 : bx_in[0] + SW'(1);
      else       by_in[1] = (by_in[0] == nr - SW'(1)) ? '0 : by_in[0] + SW'(1);
   end

   // folded distance of each pair
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            dp_in[i*2+j] = (SW+1)'(fold(ax_ff[i], bx_ff[j], nc_ff))
                         + (SW+1)'(fold(ay_ff[i], by_ff[j], nr_ff));
         end
      end
   end

   // minimum of four
   always_comb begin
      logic [SW:0] m0, m1, m;
      m0 = (dp_ff[0] < dp_ff[1]) ? dp_ff[0] : dp_ff[1];
      m1 = (dp_ff[2] < dp_ff[3]) ? dp_ff[2] : dp_ff[3];
      m  = (m0 < m1) ? m0 : m1;
      dist_in = oor2_ff ? '0 : DistWidth'(m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         valid_out <= 1'b0;
      end else if (en) begin
         v1_ff     <= valid_in;
         v2_ff     <= v1_ff;
         valid_out <= v2_ff;
      end
      if (en) begin
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         nc_ff   <= nc;
         nr_ff   <= nr;
         oor1_ff <= oor;
         dp_ff   <= dp_in;
         oor2_ff <= oor1_ff;
         dist_ff <= dist_in;
         out_of_range <= oor2_ff;
      end
   end

   assign distance = dist_ff;
endmodule
